// ===== src/bmvs_pkg.sv =====
package bmvs_pkg;

  localparam int MAX_SAMPLES = 4096;

  localparam int SAMPLE_W = 16;
  localparam int CNT_W    = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(MAX_SAMPLES);
  localparam int SQ_W     = 2 * SAMPLE_W - 1 + $clog2(MAX_SAMPLES);
  localparam int MUL_W    = SUM_W;
  localparam int NUM_W    = 2 * SUM_W;
  localparam int IT_W     = $clog2(NUM_W);

  localparam int MEAN_W   = 16;
  localparam int VAR_W    = 32;
  localparam int STD_W    = 16;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;

  localparam int ROOT_STEPS = VAR_W / 2;

  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_MUL = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD = 2'd1;
  localparam logic [OP_W-1:0] OP_SUB = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [NUM_W-1:0] a;
    logic [NUM_W-1:0] b;
    logic [MUL_W-1:0] ma;
    logic [MUL_W-1:0] mb;
  } unit_req_t;

  typedef struct packed {
    logic [NUM_W-1:0] y;
    logic             ge;
  } unit_rsp_t;

  typedef struct packed {
    logic [MEAN_W-1:0]   mean;
    logic [VAR_W-1:0]    variance;
    logic [STD_W-1:0]    std_dev;
    logic [COUNT_W-1:0]  sample_count;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

// ===== src/block_mean_variance_std_top.sv =====
// Block statistics over signed Q1.15 samples: each block ends on a sample
// with in_last set, and then one transaction gives the mean (truncated toward
// zero), the sample variance in Q2.30 units, its floor square root in Q1.15
// units, the count of samples used and a status (1 for fewer than two samples,
// 2 when samples beyond 4096 were dropped). All arithmetic runs on one shared
// multiply, add and subtract unit under a sequencer, so the block takes one
// sample at a time: a sample below the limit that does not end a block holds
// the input through accept, square and two accumulations. A closing sample
// then runs two 56-step restoring divisions and a 16-step square root on the
// shared subtracter; a block of one sample runs only the mean division. A
// finished result waits in an output register, so the next block may start
// while it is still stalled.
module block_mean_variance_std_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_mean,
  output logic [31:0]        out_variance,
  output logic [15:0]        out_std_dev,
  output logic [12:0]        out_sample_count,
  output logic [1:0]         out_status
);

  localparam int SW = bmvs_pkg::SAMPLE_W;
  localparam int CW = bmvs_pkg::CNT_W;
  localparam int UW = bmvs_pkg::SUM_W;
  localparam int QW = bmvs_pkg::SQ_W;
  localparam int MW = bmvs_pkg::MUL_W;
  localparam int NW = bmvs_pkg::NUM_W;
  localparam int IW = bmvs_pkg::IT_W;
  localparam int VW = bmvs_pkg::VAR_W;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SQ     = 5'd1;
  localparam logic [4:0] S_ADDSQ  = 5'd2;
  localparam logic [4:0] S_ADDSUM = 5'd3;
  localparam logic [4:0] S_MAG    = 5'd4;
  localparam logic [4:0] S_DIVM   = 5'd5;
  localparam logic [4:0] S_MEAN   = 5'd6;
  localparam logic [4:0] S_NLO    = 5'd7;
  localparam logic [4:0] S_NHI    = 5'd8;
  localparam logic [4:0] S_SHADD  = 5'd9;
  localparam logic [4:0] S_MAGSQ  = 5'd10;
  localparam logic [4:0] S_SUBB   = 5'd11;
  localparam logic [4:0] S_NM1    = 5'd12;
  localparam logic [4:0] S_DEN    = 5'd13;
  localparam logic [4:0] S_DIVV   = 5'd14;
  localparam logic [4:0] S_VAR    = 5'd15;
  localparam logic [4:0] S_SQRT   = 5'd16;
  localparam logic [4:0] S_OUT    = 5'd17;

  logic [4:0]    state_r, state_nxt;
  logic [SW-1:0] smp_r, smp_nxt;
  logic          last_r, last_nxt;
  logic [UW-1:0] sum_r, sum_nxt;
  logic [QW-1:0] sumsq_r, sumsq_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [NW-1:0] p_r, p_nxt;
  logic [NW-1:0] acc_r, acc_nxt;
  logic [NW-1:0] dvs_r, dvs_nxt;
  logic [NW-1:0] dvd_r, dvd_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [UW-1:0] mag_r, mag_nxt;
  logic [IW-1:0] it_r, it_nxt;
  logic [15:0]   mean_r, mean_nxt;
  logic [VW-1:0] var_r, var_nxt;
  logic [VW-1:0] root_r, root_nxt;
  logic [VW-1:0] v_r, v_nxt;

  bmvs_pkg::unit_req_t req;
  bmvs_pkg::unit_rsp_t rsp;
  bmvs_pkg::result_t   res;
  bmvs_pkg::result_t   res_q;

  logic          load_out;
  logic          ob_free;
  logic [SW:0]   smp_ext;
  logic [SW:0]   smp_abs;
  logic [NW-1:0] sum_sx;
  logic [NW-1:0] smp_sx;
  logic [NW-1:0] rem_sh;
  logic [UW-1:0] mag_sel;
  logic [VW-1:0] sq_bit;
  logic [VW-1:0] var_sat;

  bmvs_unit u_unit (
    .req (req),
    .rsp (rsp)
  );

  assign smp_ext = {smp_r[SW-1], smp_r};
  assign smp_abs = smp_r[SW-1] ? ((SW+1)'(0) - smp_ext) : smp_ext;
  assign sum_sx  = {{(NW-UW){sum_r[UW-1]}}, sum_r};
  assign smp_sx  = {{(NW-SW){smp_r[SW-1]}}, smp_r};
  assign rem_sh  = {rem_r[NW-2:0], dvd_r[NW-1]};
  assign mag_sel = sum_r[UW-1] ? rsp.y[UW-1:0] : sum_r;
  assign sq_bit  = VW'(1) << {it_r, 1'b0};
  assign var_sat = ((dvd_r >> VW) != '0) ? '1 : dvd_r[VW-1:0];

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    smp_nxt   = smp_r;
    last_nxt  = last_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    p_nxt     = p_r;
    acc_nxt   = acc_r;
    dvs_nxt   = dvs_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    mag_nxt   = mag_r;
    it_nxt    = it_r;
    mean_nxt  = mean_r;
    var_nxt   = var_r;
    root_nxt  = root_r;
    v_nxt     = v_r;
    load_out  = 1'b0;
    req       = '0;
    req.op    = bmvs_pkg::OP_ADD;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          smp_nxt  = in_sample;
          last_nxt = in_last;
          if (cnt_r < CW'(bmvs_pkg::MAX_SAMPLES)) begin
            state_nxt = S_SQ;
          end else begin
            ovf_nxt   = 1'b1;
            state_nxt = in_last ? S_MAG : S_IDLE;
          end
        end
      end
      S_SQ: begin
        req.op    = bmvs_pkg::OP_MUL;
        req.ma    = MW'(smp_abs);
        req.mb    = MW'(smp_abs);
        p_nxt     = rsp.y;
        state_nxt = S_ADDSQ;
      end
      S_ADDSQ: begin
        req.op    = bmvs_pkg::OP_ADD;
        req.a     = NW'(sumsq_r);
        req.b     = p_r;
        sumsq_nxt = rsp.y[QW-1:0];
        state_nxt = S_ADDSUM;
      end
      S_ADDSUM: begin
        req.op    = bmvs_pkg::OP_ADD;
        req.a     = sum_sx;
        req.b     = smp_sx;
        sum_nxt   = rsp.y[UW-1:0];
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = last_r ? S_MAG : S_IDLE;
      end
      S_MAG: begin
        req.op    = bmvs_pkg::OP_SUB;
        req.a     = '0;
        req.b     = sum_sx;
        mag_nxt   = mag_sel;
        dvd_nxt   = NW'(mag_sel);
        dvs_nxt   = NW'(cnt_r);
        rem_nxt   = '0;
        it_nxt    = IW'(NW - 1);
        state_nxt = S_DIVM;
      end
      S_DIVM, S_DIVV: begin
        req.op  = bmvs_pkg::OP_SUB;
        req.a   = rem_sh;
        req.b   = dvs_r;
        rem_nxt = rsp.ge ? rsp.y : rem_sh;
        dvd_nxt = {dvd_r[NW-2:0], rsp.ge};
        if (it_r == '0) begin
          state_nxt = (state_r == S_DIVM) ? S_MEAN : S_VAR;
        end else begin
          it_nxt = it_r - 1'b1;
        end
      end
      S_MEAN: begin
        req.op = bmvs_pkg::OP_SUB;
        req.a  = '0;
        req.b  = dvd_r;
        if (cnt_r == '0) begin
          mean_nxt = '0;
        end else begin
          mean_nxt = sum_r[UW-1] ? rsp.y[15:0] : dvd_r[15:0];
        end
        if (cnt_r < CW'(2)) begin
          var_nxt   = '0;
          root_nxt  = '0;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_NLO;
        end
      end
      S_NLO: begin
        req.op    = bmvs_pkg::OP_MUL;
        req.ma    = MW'(cnt_r);
        req.mb    = sumsq_r[MW-1:0];
        acc_nxt   = rsp.y;
        state_nxt = S_NHI;
      end
      S_NHI: begin
        req.op    = bmvs_pkg::OP_MUL;
        req.ma    = MW'(cnt_r);
        req.mb    = MW'(sumsq_r >> MW);
        p_nxt     = rsp.y;
        state_nxt = S_SHADD;
      end
      S_SHADD: begin
        req.op    = bmvs_pkg::OP_ADD;
        req.a     = acc_r;
        req.b     = p_r << MW;
        acc_nxt   = rsp.y;
        state_nxt = S_MAGSQ;
      end
      S_MAGSQ: begin
        req.op    = bmvs_pkg::OP_MUL;
        req.ma    = mag_r;
        req.mb    = mag_r;
        p_nxt     = rsp.y;
        state_nxt = S_SUBB;
      end
      S_SUBB: begin
        req.op    = bmvs_pkg::OP_SUB;
        req.a     = acc_r;
        req.b     = p_r;
        acc_nxt   = rsp.ge ? rsp.y : '0;
        state_nxt = S_NM1;
      end
      S_NM1: begin
        req.op    = bmvs_pkg::OP_SUB;
        req.a     = NW'(cnt_r);
        req.b     = NW'(1);
        dvs_nxt   = rsp.y;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        req.op    = bmvs_pkg::OP_MUL;
        req.ma    = MW'(cnt_r);
        req.mb    = dvs_r[MW-1:0];
        dvs_nxt   = rsp.y;
        dvd_nxt   = acc_r;
        rem_nxt   = '0;
        it_nxt    = IW'(NW - 1);
        state_nxt = S_DIVV;
      end
      S_VAR: begin
        var_nxt   = var_sat;
        v_nxt     = var_sat;
        root_nxt  = '0;
        it_nxt    = IW'(bmvs_pkg::ROOT_STEPS - 1);
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        req.op = bmvs_pkg::OP_SUB;
        req.a  = NW'(v_r);
        req.b  = NW'(root_r | sq_bit);
        if (rsp.ge) begin
          v_nxt    = rsp.y[VW-1:0];
          root_nxt = (root_r >> 1) | sq_bit;
        end else begin
          root_nxt = root_r >> 1;
        end
        if (it_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          it_nxt = it_r - 1'b1;
        end
      end
      S_OUT: begin
        if (ob_free) begin
          load_out  = 1'b1;
          sum_nxt   = '0;
          sumsq_nxt = '0;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sum_r   <= '0;
      sumsq_r <= '0;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
    smp_r  <= smp_nxt;
    last_r <= last_nxt;
    p_r    <= p_nxt;
    acc_r  <= acc_nxt;
    dvs_r  <= dvs_nxt;
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    mag_r  <= mag_nxt;
    it_r   <= it_nxt;
    mean_r <= mean_nxt;
    var_r  <= var_nxt;
    root_r <= root_nxt;
    v_r    <= v_nxt;
  end

  always_comb begin
    res.mean         = mean_r;
    res.variance     = var_r;
    res.std_dev      = root_r[bmvs_pkg::STD_W-1:0];
    res.sample_count = bmvs_pkg::COUNT_W'(cnt_r);
    if (cnt_r < CW'(2)) begin
      res.status = bmvs_pkg::ST_SHORT;
    end else if (ovf_r) begin
      res.status = bmvs_pkg::ST_DROP;
    end else begin
      res.status = bmvs_pkg::ST_OK;
    end
  end

  bmvs_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load_out),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_out   (res_q),
    .free      (ob_free)
  );

  assign out_mean         = res_q.mean;
  assign out_variance     = res_q.variance;
  assign out_std_dev      = res_q.std_dev;
  assign out_sample_count = res_q.sample_count;
  assign out_status       = res_q.status;

`ifndef SYNTHESIS
  // The running count never passes the sample limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(bmvs_pkg::MAX_SAMPLES))
    else $error("sample count above limit");

  // A sample taken below the limit is counted exactly once.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && cnt_r < CW'(bmvs_pkg::MAX_SAMPLES))
    |-> ##4 (cnt_r == CW'($past(cnt_r, 4) + 1'b1)))
    else $error("accepted sample not counted");

  // Handing a result to the output register clears the block state.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (cnt_r == '0 && sum_r == '0 && sumsq_r == '0 && !ovf_r))
    else $error("block state not cleared after result");

  // A short block reports zero variance and zero deviation.
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bmvs_pkg::ST_SHORT)
    |-> (out_variance == '0 && out_std_dev == '0))
    else $error("short block with nonzero spread");
`endif

endmodule

// ===== src/bmvs_unit.sv =====
module bmvs_unit (
  input  bmvs_pkg::unit_req_t req,
  output bmvs_pkg::unit_rsp_t rsp
);

  logic [bmvs_pkg::NUM_W-1:0] prod;
  logic [bmvs_pkg::NUM_W:0]   diff;

  assign prod = bmvs_pkg::NUM_W'(req.ma) * bmvs_pkg::NUM_W'(req.mb);
  assign diff = {1'b0, req.a} - {1'b0, req.b};

  always_comb begin
    case (req.op)
      bmvs_pkg::OP_MUL: begin
        rsp.y  = prod;
        rsp.ge = 1'b0;
      end
      bmvs_pkg::OP_ADD: begin
        rsp.y  = req.a + req.b;
        rsp.ge = 1'b0;
      end
      bmvs_pkg::OP_SUB: begin
        rsp.y  = diff[bmvs_pkg::NUM_W-1:0];
        rsp.ge = ~diff[bmvs_pkg::NUM_W];
      end
      default: begin
        rsp.y  = '0;
        rsp.ge = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/bmvs_outreg.sv =====
module bmvs_outreg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  bmvs_pkg::result_t   res_in,
  input  logic                out_stall,
  output logic                out_valid,
  output bmvs_pkg::result_t   res_out,
  output logic                free
);

  logic              valid_r;
  logic              valid_nxt;
  bmvs_pkg::result_t res_r;

  assign free      = ~valid_r | ~out_stall;
  assign valid_nxt = load | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = valid_r;
  assign res_out   = res_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_CYCLES = 1000;
  localparam int TAIL_CYCLES = 300;
  localparam int PHASE_ITEMS = 330;

  typedef enum int {FILL_RANDOM, FILL_EXTREME, FILL_CLUSTER} fill_t;

  class stats_scoreboard;
    longint            acc_sum;
    longint unsigned   acc_sumsq;
    int                acc_count;
    bit                acc_dropped;
    bmvs_pkg::result_t pending_stats[$];
    int unsigned       errors;

    function new();
      clear_block();
      errors = 0;
    endfunction

    function void clear_block();
      acc_sum     = 0;
      acc_sumsq   = 0;
      acc_count   = 0;
      acc_dropped = 1'b0;
    endfunction

    function logic [bmvs_pkg::STD_W-1:0] floor_root(logic [bmvs_pkg::VAR_W-1:0] v);
      logic [bmvs_pkg::STD_W-1:0] root;
      logic [bmvs_pkg::STD_W-1:0] trial;
      root = '0;
      for (int k = bmvs_pkg::STD_W - 1; k >= 0; k--) begin
        trial = root | (bmvs_pkg::STD_W'(1) << k);
        if (bmvs_pkg::VAR_W'(trial) * bmvs_pkg::VAR_W'(trial) <= v) root = trial;
      end
      return root;
    endfunction

    function void take_sample(logic signed [bmvs_pkg::SAMPLE_W-1:0] s, logic is_last);
      bmvs_pkg::result_t r;
      longint unsigned   n;
      longint unsigned   mag;
      longint unsigned   a;
      longint unsigned   b;
      longint unsigned   spread;
      if (acc_count < bmvs_pkg::MAX_SAMPLES) begin
        acc_sum   += longint'(s);
        acc_sumsq += longint'(s) * longint'(s);
        acc_count++;
      end else begin
        acc_dropped = 1'b1;
      end
      if (!is_last) return;
      n = acc_count;
      r.mean = (acc_count != 0) ?
               bmvs_pkg::MEAN_W'(acc_sum / longint'(acc_count)) : '0;
      r.sample_count = bmvs_pkg::COUNT_W'(n);
      if (n < 2) begin
        r.variance = '0;
        r.std_dev  = '0;
        r.status   = bmvs_pkg::ST_SHORT;
      end else begin
        mag    = $unsigned((acc_sum < 0) ? -acc_sum : acc_sum);
        a      = n * acc_sumsq;
        b      = mag * mag;
        spread = (a >= b) ? (a - b) / (n * (n - 1)) : 0;
        if (spread > 64'hFFFF_FFFF) spread = 64'hFFFF_FFFF;
        r.variance = bmvs_pkg::VAR_W'(spread);
        r.std_dev  = floor_root(r.variance);
        r.status   = acc_dropped ? bmvs_pkg::ST_DROP : bmvs_pkg::ST_OK;
      end
      pending_stats.push_back(r);
      clear_block();
    endfunction

    function void check_stats(bmvs_pkg::result_t got);
      bmvs_pkg::result_t want;
      if (pending_stats.size() == 0) begin
        if (errors < 10) begin
          $display("unexpected result: mean %0d variance %0d std %0d count %0d status %0d",
                   $signed(got.mean), got.variance, got.std_dev, got.sample_count,
                   got.status);
        end
        errors++;
        return;
      end
      want = pending_stats.pop_front();
      if (got.mean !== want.mean || got.variance !== want.variance ||
          got.std_dev !== want.std_dev || got.sample_count !== want.sample_count ||
          got.status !== want.status) begin
        if (errors < 10) begin
          $display("stats mismatch at %0t:", $time);
          $display("  expected mean %0d variance %0d std %0d count %0d status %0d",
                   $signed(want.mean), want.variance, want.std_dev,
                   want.sample_count, want.status);
          $display("  actual   mean %0d variance %0d std %0d count %0d status %0d",
                   $signed(got.mean), got.variance, got.std_dev, got.sample_count,
                   got.status);
        end
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_sample = '0;
  logic               in_last   = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_mean;
  logic [31:0]        out_variance;
  logic [15:0]        out_std_dev;
  logic [12:0]        out_sample_count;
  logic [1:0]         out_status;

  stats_scoreboard   stats = new();
  bmvs_pkg::result_t seen_stats;
  int                send_idle_pct  = 10;
  int                recv_stall_pct = 51;
  int                items_sent     = 0;
  int                idle_cycles    = 0;
  int                hold_left      = 0;
  bit                hold_go        = 1'b0;
  bit                hold_taken     = 1'b0;

  block_mean_variance_std_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_mean         (out_mean),
    .out_variance     (out_variance),
    .out_std_dev      (out_std_dev),
    .out_sample_count (out_sample_count),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_stats.mean         = out_mean;
      seen_stats.variance     = out_variance;
      seen_stats.std_dev      = out_std_dev;
      seen_stats.sample_count = out_sample_count;
      seen_stats.status       = out_status;
      stats.check_stats(seen_stats);
    end
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic logic signed [15:0] pick_sample(fill_t style,
                                                     logic signed [15:0] base);
    case (style)
      FILL_RANDOM: return 16'($urandom);
      FILL_EXTREME: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'shFFFF;
          default: return 16'sh0000;
        endcase
      end
      default: return base + 16'($urandom_range(63)) - 16'sd32;
    endcase
  endfunction

  task automatic send_sample(logic signed [15:0] s, logic is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_last   <= is_last;
    do @(posedge clk); while (in_stall);
    stats.take_sample(s, is_last);
    items_sent++;
  endtask

  task automatic send_block(int len, fill_t style);
    logic signed [15:0] base;
    base = 16'($urandom);
    for (int j = 0; j < len; j++) send_sample(pick_sample(style, base), j == len - 1);
  endtask

  task automatic send_random_blocks(int count);
    int stop;
    int len;
    stop = items_sent + count;
    while (items_sent < stop) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 150) : $urandom_range(1, 12);
      send_block(len, fill_t'($urandom_range(2)));
    end
  endtask

  initial begin
    int lens[$];
    int vals[$];
    int k;
    lens = {1, 1, 2, 2, 3, 4, 3, 2, 2, 2};
    vals = {-32768, 32767, -32768, 32767, 32767, 32767, -3, -2, 0,
            -32768, 32767, -32768, 32767, 0, 0, 0, -1, 0, 1, 2, 0, 3};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    k = 0;
    foreach (lens[b]) begin
      for (int j = 0; j < lens[b]; j++) begin
        send_sample(16'(vals[k]), j == lens[b] - 1);
        k++;
      end
    end

    send_random_blocks(PHASE_ITEMS);
    send_idle_pct  = 51;
    recv_stall_pct = 10;
    send_random_blocks(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go <= 1'b1;
    send_random_blocks(PHASE_ITEMS);
    in_valid <= 1'b0;

    while (stats.pending_stats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (stats.errors == 0 && stats.pending_stats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== block_mean_variance_std_top.f =====
src/bmvs_pkg.sv
src/bmvs_unit.sv
src/bmvs_outreg.sv
src/block_mean_variance_std_top.sv
tb/sv/tb.sv
